// ===== sv/nmea_sentence_checksum_framer_defines.svh =====
// assertion macros for the nmea sentence checksum framer
// included by the top level only; needs clk and rst_n in scope
`ifndef NMEA_SENTENCE_CHECKSUM_FRAMER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_FRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NSCF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define NSCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nscf_pkg.sv =====
// shared types and constants for the nmea sentence checksum framer
// no dependencies
package nscf_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_HDT = 24'h484454;
  localparam logic [23:0] TYPE_TRA = 24'h545241;
  localparam logic [23:0] TYPE_RMC = 24'h524D43;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_HDT   = 3'd2;
  localparam logic [2:0] KIND_TRA   = 3'd3;
  localparam logic [2:0] KIND_RMC   = 3'd4;
  localparam logic [2:0] KIND_OTHER = 3'd5;

  localparam logic [5:0] MIN_FIELDS_GGA = 6'd10;
  localparam logic [5:0] MIN_FIELDS_HDT = 6'd2;
  localparam logic [5:0] MIN_FIELDS_TRA = 6'd6;
  localparam logic [5:0] MIN_FIELDS_RMC = 6'd9;
  localparam logic [5:0] FIELDS_MAX     = 6'd63;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } nscf_in_t;

  typedef struct packed {
    logic        start_found;
    logic        checksum_ok;
    logic [2:0]  sentence_kind;
    logic [23:0] type_letters;
    logic [5:0]  field_count;
    logic        recognized;
  } nscf_out_t;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       is_eol;
    logic       hex_ok;
    logic [3:0] hex_val;
  } nscf_class_t;

endpackage

// ===== sv/nscf_front.sv =====
// front end: accepts input bytes and classifies them into a register
// depends on nscf_pkg
module nscf_front import nscf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  nscf_in_t    in_data,
  output logic        cls_valid,
  input  logic        cls_ready,
  output nscf_class_t cls_data
);

  logic        valid_r;
  logic        valid_nxt;
  nscf_class_t cls_r;
  nscf_class_t cls_nxt;
  logic [7:0]  b;

  assign b = in_data.data_byte;
  assign in_ready = !valid_r || cls_ready;

  always_comb begin
    cls_nxt.data_byte = b;
    cls_nxt.last      = in_data.last;
    cls_nxt.is_dollar = (b == CH_DOLLAR);
    cls_nxt.is_star   = (b == CH_STAR);
    cls_nxt.is_comma  = (b == CH_COMMA);
    cls_nxt.is_eol    = (b == CH_CR) || (b == CH_LF);
    cls_nxt.hex_ok    = 1'b1;
    cls_nxt.hex_val   = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      cls_nxt.hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      // letters a-f: low nibble 1..6 maps to 10..15
      cls_nxt.hex_val = b[3:0] + 4'd9;
    end else begin
      cls_nxt.hex_ok = 1'b0;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = valid_r;
  assign cls_data  = cls_r;

endmodule

// ===== sv/nscf_queue.sv =====
// short queue of classified bytes between front and back
// depends on nscf_pkg
module nscf_queue import nscf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push_valid,
  output logic        push_ready,
  input  nscf_class_t push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output nscf_class_t pop_data
);

  nscf_class_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r;
  logic [QPTR_W-1:0]       wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r;
  logic [QPTR_W-1:0]       rd_ptr_nxt;
  logic [QPTR_W:0]         count_r;
  logic [QPTR_W:0]         count_nxt;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count_r != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/nscf_back.sv =====
// back end: sentence state, checksum and field counting, result register
// depends on nscf_pkg
module nscf_back import nscf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cls_valid,
  output logic        cls_ready,
  input  nscf_class_t cls_data,
  output logic        out_valid,
  input  logic        out_ready,
  output nscf_out_t   out_data
);

  logic        started_r, started_nxt;
  logic [2:0]  offset_r, offset_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        star_r, star_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        bad_hex_r, bad_hex_nxt;
  logic [23:0] type_r, type_nxt;
  logic [5:0]  commas_r, commas_nxt;
  logic        split_end_r, split_end_nxt;
  logic        field1_r, field1_nxt;
  logic        out_valid_r, out_valid_nxt;
  nscf_out_t   out_r;
  nscf_out_t   res;
  logic        take;
  logic        emit;

  // a last byte needs the result register free (or draining this cycle)
  assign cls_ready = !cls_data.last || !out_valid_r || out_ready;
  assign take      = cls_valid && cls_ready;
  assign emit      = take && cls_data.last;

  always_comb begin
    started_nxt   = started_r;
    offset_nxt    = offset_r;
    xor_nxt       = xor_r;
    star_nxt      = star_r;
    digits_nxt    = digits_r;
    sum_nxt       = sum_r;
    bad_hex_nxt   = bad_hex_r;
    type_nxt      = type_r;
    commas_nxt    = commas_r;
    split_end_nxt = split_end_r;
    field1_nxt    = field1_r;
    if (!started_r) begin
      if (cls_data.is_dollar) begin
        started_nxt = 1'b1;
        offset_nxt  = 3'd1;
      end
    end else begin
      if (offset_r >= 3'd3 && offset_r <= 3'd5) begin
        type_nxt = {type_r[15:0], cls_data.data_byte};
      end
      if (offset_r < 3'd6) begin
        offset_nxt = offset_r + 3'd1;
      end
      if (!star_r) begin
        if (cls_data.is_star) begin
          star_nxt = 1'b1;
        end else begin
          xor_nxt = xor_r ^ cls_data.data_byte;
        end
      end else if (digits_r < 2'd2) begin
        if (!cls_data.hex_ok) begin
          bad_hex_nxt = 1'b1;
        end
        sum_nxt    = {sum_r[3:0], cls_data.hex_ok ? cls_data.hex_val : 4'd0};
        digits_nxt = digits_r + 2'd1;
      end
      if (!split_end_r) begin
        if (cls_data.is_star || cls_data.is_eol) begin
          split_end_nxt = 1'b1;
        end else if (cls_data.is_comma) begin
          if (commas_r != FIELDS_MAX) begin
            commas_nxt = commas_r + 6'd1;
          end
        end else if (commas_r == 6'd1) begin
          field1_nxt = 1'b1;
        end
      end
    end
  end

  // result from the state as it stands after this byte
  always_comb begin
    res = '0;
    if (started_nxt) begin
      res.start_found = 1'b1;
      res.checksum_ok = !star_nxt ||
                        (digits_nxt == 2'd2 && !bad_hex_nxt && sum_nxt == xor_nxt);
      res.field_count = (commas_nxt != FIELDS_MAX) ? commas_nxt + 6'd1 : FIELDS_MAX;
      if (offset_nxt >= 3'd6) begin
        res.type_letters = type_nxt;
        if (type_nxt == TYPE_GGA) begin
          res.sentence_kind = KIND_GGA;
        end else if (type_nxt == TYPE_HDT) begin
          res.sentence_kind = KIND_HDT;
        end else if (type_nxt == TYPE_TRA) begin
          res.sentence_kind = KIND_TRA;
        end else if (type_nxt == TYPE_RMC) begin
          res.sentence_kind = KIND_RMC;
        end else begin
          res.sentence_kind = KIND_OTHER;
        end
      end
      if (res.checksum_ok) begin
        unique case (res.sentence_kind)
          KIND_GGA: res.recognized = (res.field_count >= MIN_FIELDS_GGA);
          KIND_HDT: res.recognized = (res.field_count >= MIN_FIELDS_HDT) && field1_nxt;
          KIND_TRA: res.recognized = (res.field_count >= MIN_FIELDS_TRA);
          KIND_RMC: res.recognized = (res.field_count >= MIN_FIELDS_RMC);
          default:  res.recognized = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      started_r   <= 1'b0;
      offset_r    <= '0;
      xor_r       <= '0;
      star_r      <= 1'b0;
      digits_r    <= '0;
      sum_r       <= '0;
      bad_hex_r   <= 1'b0;
      type_r      <= '0;
      commas_r    <= '0;
      split_end_r <= 1'b0;
      field1_r    <= 1'b0;
    end else if (take) begin
      started_r   <= started_nxt;
      offset_r    <= offset_nxt;
      xor_r       <= xor_nxt;
      star_r      <= star_nxt;
      digits_r    <= digits_nxt;
      sum_r       <= sum_nxt;
      bad_hex_r   <= bad_hex_nxt;
      type_r      <= type_nxt;
      commas_r    <= commas_nxt;
      split_end_r <= split_end_nxt;
      field1_r    <= field1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== sv/nmea_sentence_checksum_framer.sv =====
// top level of the nmea sentence checksum framer
// depends on nscf_pkg, nscf_front, nscf_queue, nscf_back and the defines header
//
// Input channel in_valid/in_ready/in_data carries one sentence byte per
// transaction, with in_data.last marking the final byte of the sentence.
// Output channel out_valid/out_ready/out_data carries one result per
// sentence: start flag, checksum verdict, sentence kind, type letters,
// field count and the recognised flag.
// Throughput is one byte per cycle unless the back end holds a last byte for
// a full result register; bytes other than a sentence's last keep flowing while an
// earlier result waits.
// A result passes from its last byte through the classification register,
// the two-entry queue and the result register, in that order.
// When the receiver stalls, the result is held; following bytes keep
// filling the queue and in_ready drops only once a further last byte
// finds the result register still full and the queue and the front
// register have filled.
// Synchronous reset (rst_n low) empties the queue, drops out_valid and
// clears all sentence state; no clearing pass is needed.
`include "nmea_sentence_checksum_framer_defines.svh"
module nmea_sentence_checksum_framer import nscf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  nscf_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output nscf_out_t out_data
);

  logic        cls_valid;
  logic        cls_ready;
  nscf_class_t cls_data;
  logic        q_valid;
  logic        q_ready;
  nscf_class_t q_data;
  logic        no_start_shown;
  logic        res_empty;
  logic        recog_shown;
  logic        recog_allowed;
  logic        started_shown;
  logic        fields_present;
  logic        q_stalled;

  nscf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data)
  );

  nscf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_data  (cls_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  nscf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign no_start_shown = out_valid && !out_data.start_found;
  assign res_empty      = !out_data.checksum_ok && out_data.sentence_kind == KIND_NONE &&
                          out_data.field_count == 6'd0 && !out_data.recognized;
  assign recog_shown    = out_valid && out_data.recognized;
  assign recog_allowed  = out_data.checksum_ok &&
                          (out_data.sentence_kind == KIND_GGA ||
                           out_data.sentence_kind == KIND_HDT ||
                           out_data.sentence_kind == KIND_TRA ||
                           out_data.sentence_kind == KIND_RMC);
  assign started_shown  = out_valid && out_data.start_found;
  assign fields_present = (out_data.field_count != 6'd0);
  assign q_stalled      = q_valid && !q_ready;

  // no start means an all-empty verdict
  `NSCF_ASSERT_IMP(a_no_start_empty, no_start_shown, res_empty, "result without start is not empty")
  // recognised needs a passing checksum and a known kind
  `NSCF_ASSERT_IMP(a_recog_ok, recog_shown, recog_allowed, "recognised result not allowed")
  // a started sentence always has at least one field
  `NSCF_ASSERT_IMP(a_started_fields, started_shown, fields_present, "zero fields after start")
  // a queued byte is never lost while the back end stalls on a full result register
  `NSCF_ASSERT_NEXT(a_queue_holds, q_stalled, q_valid, "queued byte vanished while stalled")

endmodule

// ===== bench/nscf_sentence_checker.sv =====
// result checker for the nmea sentence checksum framer: follows both channels,
// predicts each sentence verdict and compares it with what the block returns
// depends on nscf_pkg
module nscf_sentence_checker import nscf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  nscf_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  nscf_out_t out_data,
  output int        mismatch_count,
  output int        results_pending
);

  typedef struct packed {
    logic        started;
    logic [2:0]  offset;
    logic [7:0]  xor_acc;
    logic        star_seen;
    logic [1:0]  digits;
    logic [7:0]  rx_sum;
    logic        bad_hex;
    logic [23:0] type_bytes;
    logic [5:0]  commas;
    logic        fields_done;
    logic        field1_nonempty;
  } sentence_state_t;

  sentence_state_t sentence_q;
  nscf_out_t       verdicts_due[$];
  int              errors;

  // top bit flags a valid digit, low nibble is its value (zero when invalid)
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
    return 5'd0;
  endfunction

  function automatic sentence_state_t absorb_byte(input sentence_state_t s,
                                                  input logic [7:0] b);
    sentence_state_t n;
    logic [4:0]      hx;
    n = s;
    if (!s.started) begin
      if (b == CH_DOLLAR) begin
        n.started = 1'b1;
        n.offset  = 3'd1;
      end
      return n;
    end
    if (s.offset >= 3'd3 && s.offset <= 3'd5) n.type_bytes = {s.type_bytes[15:0], b};
    if (s.offset < 3'd6) n.offset = s.offset + 3'd1;
    if (!s.star_seen) begin
      if (b == CH_STAR) n.star_seen = 1'b1;
      else n.xor_acc = s.xor_acc ^ b;
    end else if (s.digits < 2'd2) begin
      hx = hex_nibble(b);
      if (!hx[4]) n.bad_hex = 1'b1;
      n.rx_sum = {s.rx_sum[3:0], hx[3:0]};
      n.digits = s.digits + 2'd1;
    end
    if (!s.fields_done) begin
      if (b == CH_STAR || b == CH_CR || b == CH_LF) begin
        n.fields_done = 1'b1;
      end else if (b == CH_COMMA) begin
        if (s.commas != FIELDS_MAX) n.commas = s.commas + 6'd1;
      end else if (s.commas == 6'd1) begin
        n.field1_nonempty = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic nscf_out_t sentence_verdict(input sentence_state_t s);
    nscf_out_t r;
    r = '0;
    if (s.started) begin
      r.start_found = 1'b1;
      r.checksum_ok = !s.star_seen ||
                      (s.digits == 2'd2 && !s.bad_hex && s.rx_sum == s.xor_acc);
      r.field_count = (s.commas < FIELDS_MAX) ? s.commas + 6'd1 : FIELDS_MAX;
      if (s.offset >= 3'd6) begin
        r.type_letters = s.type_bytes;
        case (s.type_bytes)
          TYPE_GGA: r.sentence_kind = KIND_GGA;
          TYPE_HDT: r.sentence_kind = KIND_HDT;
          TYPE_TRA: r.sentence_kind = KIND_TRA;
          TYPE_RMC: r.sentence_kind = KIND_RMC;
          default:  r.sentence_kind = KIND_OTHER;
        endcase
      end
      if (r.checksum_ok) begin
        case (r.sentence_kind)
          KIND_GGA: r.recognized = (r.field_count >= MIN_FIELDS_GGA);
          KIND_HDT: r.recognized = (r.field_count >= MIN_FIELDS_HDT) && s.field1_nonempty;
          KIND_TRA: r.recognized = (r.field_count >= MIN_FIELDS_TRA);
          KIND_RMC: r.recognized = (r.field_count >= MIN_FIELDS_RMC);
          default:  r.recognized = 1'b0;
        endcase
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(input string what, input nscf_out_t want,
                              input nscf_out_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: expected start=%b ok=%b kind=%0d type=%h fields=%0d rec=%b",
               $realtime, what,
               want.start_found, want.checksum_ok, want.sentence_kind,
               want.type_letters, want.field_count, want.recognized);
      $display("%0t %s: actual   start=%b ok=%b kind=%0d type=%h fields=%0d rec=%b",
               $realtime, what,
               got.start_found, got.checksum_ok, got.sentence_kind,
               got.type_letters, got.field_count, got.recognized);
    end
  endtask

  always @(posedge clk) begin
    nscf_out_t want;
    if (!rst_n) begin
      sentence_q = '0;
      verdicts_due.delete();
    end else begin
      // result side first: a verdict never leaves in the cycle its last byte arrives
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          log_mismatch("result with nothing outstanding", '0, out_data);
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.start_found   !== want.start_found   ||
              out_data.checksum_ok   !== want.checksum_ok   ||
              out_data.sentence_kind !== want.sentence_kind ||
              out_data.type_letters  !== want.type_letters  ||
              out_data.field_count   !== want.field_count   ||
              out_data.recognized    !== want.recognized)
            log_mismatch("result mismatch", want, out_data);
        end
      end
      if (in_valid && in_ready) begin
        sentence_q = absorb_byte(sentence_q, in_data.data_byte);
        if (in_data.last) begin
          verdicts_due.insert(verdicts_due.size(), sentence_verdict(sentence_q));
          sentence_q = '0;
        end
      end
    end
    mismatch_count  <= errors;
    results_pending <= verdicts_due.size();
  end

endmodule

// ===== bench/nmea_sentence_checksum_framer_tb.sv =====
// testbench top for the nmea sentence checksum framer: builds sentences,
// drives both handshakes with random idling and gives the verdict
// depends on nscf_pkg, nscf_sentence_checker and the framer rtl
module nmea_sentence_checksum_framer_tb;
  import nscf_pkg::*;

  localparam logic [7:0] CHR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam int RANDOM_BYTES    = 640;
  localparam int HOLD_OFF_CYCLES = 800;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  nscf_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  nscf_out_t out_data;
  int        mismatch_count;
  int        results_pending;

  logic [7:0] line_bytes[$];
  int         random_sent;

  nmea_sentence_checksum_framer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  nscf_sentence_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CHR_DIGIT0 + 8'(n);
    return (lower ? CHR_LOWER_A : CHR_UPPER_A) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      0:       return CHR_DOT;
      1:       return CHR_UPPER_A + 8'($urandom_range(0, 25));
      2:       return ($urandom_range(0, 3) == 0) ? CH_DOLLAR : CHR_DOT;
      default: return CHR_DIGIT0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) append_byte(t[i]);
  endtask

  // xor of everything after the first start byte, then star and two digits
  task automatic push_checksum(input bit lower, input bit corrupt);
    logic [7:0] sum;
    bit         after_start;
    sum = 8'd0;
    after_start = 1'b0;
    foreach (line_bytes[i]) begin
      if (after_start) sum ^= line_bytes[i];
      else if (line_bytes[i] == CH_DOLLAR) after_start = 1'b1;
    end
    if (corrupt) sum ^= 8'(1 << $urandom_range(0, 7));
    append_byte(CH_STAR);
    append_byte(hex_char(sum[7:4], lower));
    append_byte(hex_char(sum[3:0], lower));
  endtask

  task automatic build_random_line();
    int          style;
    int          nfields;
    int          ending;
    int          cut;
    logic [23:0] word;
    int          min_fields;
    line_bytes.delete();
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (style < 25)
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
    append_byte(CH_DOLLAR);
    repeat (2) append_byte(CHR_UPPER_A + 8'($urandom_range(0, 25)));
    case ($urandom_range(0, 4))
      0: begin word = TYPE_GGA; min_fields = int'(MIN_FIELDS_GGA); end
      1: begin word = TYPE_HDT; min_fields = int'(MIN_FIELDS_HDT); end
      2: begin word = TYPE_TRA; min_fields = int'(MIN_FIELDS_TRA); end
      3: begin word = TYPE_RMC; min_fields = int'(MIN_FIELDS_RMC); end
      default: begin
        word = {CHR_UPPER_A + 8'($urandom_range(0, 25)),
                CHR_UPPER_A + 8'($urandom_range(0, 25)),
                CHR_UPPER_A + 8'($urandom_range(0, 25))};
        min_fields = 4;
      end
    endcase
    append_byte(word[23:16]);
    append_byte(word[15:8]);
    append_byte(word[7:0]);
    nfields = min_fields + $urandom_range(0, 3) - 2;
    if (nfields < 1) nfields = 1;
    if ($urandom_range(0, 32) == 0) nfields = $urandom_range(60, 68);
    for (int f = 1; f < nfields; f++) begin
      append_byte(CH_COMMA);
      if (!(f == 1 && $urandom_range(0, 4) == 0))
        repeat ($urandom_range(f == 1 ? 1 : 0, 2)) append_byte(field_char());
    end
    ending = $urandom_range(0, 99);
    if (ending < 55) begin
      push_checksum(1'($urandom_range(0, 1)), 1'b0);
    end else if (ending < 65) begin
      push_checksum(1'($urandom_range(0, 1)), 1'b1);
    end else if (ending < 72) begin
      // no star at all
    end else if (ending < 77) begin
      append_byte(CH_STAR);
    end else if (ending < 81) begin
      append_byte(CH_STAR);
      append_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end else if (ending < 87) begin
      append_byte(CH_STAR);
      if ($urandom_range(0, 1)) begin
        append_byte(8'($urandom_range(0, 255)));
        append_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end else begin
        append_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
        append_byte(8'($urandom_range(0, 255)));
      end
    end else if (ending < 93) begin
      push_checksum(1'($urandom_range(0, 1)), 1'b0);
      repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      cut = $urandom_range(1, line_bytes.size());
      while (line_bytes.size() > cut) void'(line_bytes.pop_back());
      return;
    end
    if ($urandom_range(0, 1)) begin
      append_byte(CH_CR);
      append_byte(CH_LF);
    end
  endtask

  // one transaction per byte, last flagged on the final one
  task automatic send_line();
    int gap;
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (line_bytes[i]) begin
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{data_byte: line_bytes[i], last: (i == line_bytes.size() - 1)};
      do @(posedge clk); while (!in_ready);
    end
    line_bytes.delete();
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // receiver: random stall per result, calm stretches, two long hold-offs
  initial begin
    int stall;
    int taken;
    bit eager;
    out_ready <= 1'b0;
    taken = 0;
    eager = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 8 == 0) eager = ($urandom_range(0, 2) == 0);
      stall = eager ? 0 : $urandom_range(0, 9);
      if (taken == 4 || taken == 24) stall = HOLD_OFF_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    bit paused;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    paused = 1'b0;
    random_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no start byte, single byte
    append_byte(8'h00);
    send_line();
    // noise then a bare start
    append_byte(8'hFF);
    append_byte(CH_DOLLAR);
    send_line();
    // one byte short of the type letters
    push_text("$GPGG");
    send_line();
    // ends right on the last type letter
    push_text("$GPRMC");
    send_line();
    push_text("$GPGGA,1,2,3,4,5,6,7,8,9");
    push_checksum(1'b0, 1'b0);
    append_byte(CH_CR);
    append_byte(CH_LF);
    send_line();
    push_text("$GPGGA,1,2,3,4,5,6,7,8");
    push_checksum(1'b1, 1'b0);
    send_line();
    push_text("$HEHDT,271.5,T");
    push_checksum(1'b1, 1'b0);
    send_line();
    // heading field left empty
    push_text("$HEHDT,,T");
    push_checksum(1'b0, 1'b0);
    send_line();
    push_text("$GPTRA,1,2,3,4,5");
    push_checksum(1'b0, 1'b0);
    send_line();
    push_text("$GPRMC,1,2,3,4,5,6,7,8");
    push_checksum(1'b0, 1'b0);
    send_line();
    push_text("$GPXYZ,1");
    push_checksum(1'b0, 1'b1);
    send_line();
    // star with no digits, with one digit, with a non-hex digit
    push_text("$GPGGA,1*");
    send_line();
    push_text("$GPGGA,1*4");
    send_line();
    push_text("$GPHDT,1*G0");
    send_line();
    // bytes after the digits, including a second start byte
    push_text("$GPHDT,1");
    push_checksum(1'b1, 1'b0);
    push_text("$,9*");
    send_line();
    // punctuation in the type letter positions
    push_text("$GP,*,,1");
    push_checksum(1'b0, 1'b0);
    send_line();
    // field counting stops at a carriage return
    push_text("$GPTRA,1\r,2,3,4,5,6");
    push_checksum(1'b0, 1'b0);
    send_line();
    // field count saturates
    push_text("$GPRMC");
    repeat (70) append_byte(CH_COMMA);
    push_checksum(1'b1, 1'b0);
    send_line();
    wait_for_drain();

    while (random_sent < RANDOM_BYTES) begin
      build_random_line();
      random_sent += line_bytes.size();
      send_line();
      if (!paused && random_sent >= RANDOM_BYTES / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
